/* design/npnp_pkg.sv */
// Package for the nearest-palette nibble packer.
// Holds widths, the pixel and palette types and the cell-to-cell link struct.
`timescale 1ns / 1ps

package npnp_pkg;

    localparam int PALETTE_ENTRIES = 16;
    localparam int CHANNEL_BITS    = 8;

    localparam int PAIR_COUNT      = 8;
    localparam int PAIR_INDEX_BITS = $clog2(PAIR_COUNT);
    localparam int REG_BITS        = 48;
    localparam int IN_CHAN_BITS    = 8;
    localparam int NIBBLE_BITS     = 4;
    localparam int BYTE_BITS       = 2 * NIBBLE_BITS;
    localparam int WORD_BITS       = 3 * CHANNEL_BITS;
    localparam int EXT_BITS        = (2 * WORD_BITS > REG_BITS) ? 2 * WORD_BITS : REG_BITS;
    localparam int SQ_BITS         = 2 * CHANNEL_BITS;
    localparam int DIST_BITS       = SQ_BITS + 2;

    typedef logic [CHANNEL_BITS-1:0] chan_t;
    typedef logic [NIBBLE_BITS-1:0]  nibble_t;
    typedef logic [DIST_BITS-1:0]    dist_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } rgb_t;

    typedef struct packed {
        logic    valid;
        rgb_t    pix;
        logic    row_end;
        dist_t   best_dist;
        nibble_t best_idx;
    } link_t;

endpackage

/* design/npnp_pixel_if.sv */
// Pixel channel: valid/ready handshake carrying one RGB pixel and a row-end mark.
// Depends on nothing.
`timescale 1ns / 1ps

interface npnp_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_end;

    modport source (output valid, output red, output green, output blue, output row_end,
                    input ready);
    modport sink   (input valid, input red, input green, input blue, input row_end,
                    output ready);
endinterface

/* design/npnp_byte_if.sv */
// Packed-byte channel: valid/ready handshake carrying two indices and a row-done flag.
// Depends on nothing.
`timescale 1ns / 1ps

interface npnp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] packed_byte;
    logic       row_done;

    modport source (output valid, output packed_byte, output row_done, input ready);
    modport sink   (input valid, input packed_byte, input row_done, output ready);
endinterface

/* design/npnp_cell.sv */
// One palette cell: distance of the passing pixel to its entry, keeps the nearer.
// Depends on npnp_pkg.
`timescale 1ns / 1ps

module npnp_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  npnp_pkg::nibble_t cell_index,
    input  npnp_pkg::rgb_t   entry,
    input  npnp_pkg::link_t  link_in,
    output npnp_pkg::link_t  link_out
);
    import npnp_pkg::*;

    link_t link_reg;
    link_t link_next;

    chan_t  dr, dg, db;
    logic [SQ_BITS-1:0] sr, sg, sb;
    dist_t  sq_dist;
    logic   take;

    always_comb
    begin
        dr = (link_in.pix.red > entry.red) ? link_in.pix.red - entry.red
                                           : entry.red - link_in.pix.red;
        dg = (link_in.pix.green > entry.green) ? link_in.pix.green - entry.green
                                               : entry.green - link_in.pix.green;
        db = (link_in.pix.blue > entry.blue) ? link_in.pix.blue - entry.blue
                                             : entry.blue - link_in.pix.blue;
        sr = SQ_BITS'(dr) * SQ_BITS'(dr);
        sg = SQ_BITS'(dg) * SQ_BITS'(dg);
        sb = SQ_BITS'(db) * SQ_BITS'(db);
        sq_dist = DIST_BITS'(sr) + DIST_BITS'(sg) + DIST_BITS'(sb);
        // first entry always seeds; ties keep the lower index
        take = (cell_index == '0) || (sq_dist < link_in.best_dist);

        link_next = link_in;
        if (take)
        begin
            link_next.best_dist = sq_dist;
            link_next.best_idx  = cell_index;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg <= '0;
        end
        else if (en)
        begin
            link_reg <= link_next;
        end
    end

    assign link_out = link_reg;

endmodule

/* design/npnp_packer.sv */
// Packs chosen indices two per byte and holds the result in an output register.
// Depends on npnp_pkg and npnp_byte_if.
`timescale 1ns / 1ps

module npnp_packer (
    input  logic            clk,
    input  logic            rst_n,
    input  npnp_pkg::link_t link_in,
    output logic            en,
    npnp_byte_if.source     packed_bytes
);
    import npnp_pkg::*;

    nibble_t held_reg, held_next;
    logic    half_reg, half_next;
    logic    out_valid_reg, out_valid_next;
    logic [BYTE_BITS-1:0] byte_reg, byte_next;
    logic    done_reg, done_next;

    assign en = !out_valid_reg || packed_bytes.ready;

    always_comb
    begin
        held_next      = held_reg;
        half_next      = half_reg;
        out_valid_next = out_valid_reg;
        byte_next      = byte_reg;
        done_next      = done_reg;
        if (en)
        begin
            out_valid_next = 1'b0;
            if (link_in.valid)
            begin
                if (half_reg)
                begin
                    byte_next      = {held_reg, link_in.best_idx};
                    done_next      = link_in.row_end;
                    out_valid_next = 1'b1;
                    half_next      = 1'b0;
                    held_next      = '0;
                end
                else if (link_in.row_end)
                begin
                    byte_next      = {link_in.best_idx, NIBBLE_BITS'(0)};
                    done_next      = 1'b1;
                    out_valid_next = 1'b1;
                end
                else
                begin
                    held_next = link_in.best_idx;
                    half_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            half_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            held_reg      <= held_next;
            half_reg      <= half_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        done_reg <= done_next;
    end

    assign packed_bytes.valid       = out_valid_reg;
    assign packed_bytes.packed_byte = byte_reg;
    assign packed_bytes.row_done    = done_reg;

endmodule

/* design/nearest_palette_nibble_packer.sv */
// Nearest-palette nibble packer: a chain of PALETTE_ENTRIES cells, then the packer.
// Path: each cell's register in chain order, then the packer's output register.
// Throughput: one pixel per cycle; the whole chain stalls only while a byte waits.
// Reset: palette registers, pending nibble and all valid bits clear at once.
// Depends on npnp_pkg, npnp_pixel_if, npnp_byte_if, npnp_cell, npnp_packer.
`timescale 1ns / 1ps

module nearest_palette_nibble_packer (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [npnp_pkg::PAIR_INDEX_BITS-1:0]  cfg_index,
    input  logic [npnp_pkg::REG_BITS-1:0]         cfg_data,
    npnp_pixel_if.sink                            pixel,
    npnp_byte_if.source                           packed_bytes
);
    import npnp_pkg::*;

    logic [REG_BITS-1:0] pair_reg [PAIR_COUNT];
    link_t links [PALETTE_ENTRIES+1];
    logic  en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PAIR_COUNT; k++)
            begin
                pair_reg[k] <= '0;
            end
        end
        else if (cfg_we)
        begin
            pair_reg[cfg_index] <= cfg_data;
        end
    end

    assign pixel.ready = en;

    always_comb
    begin
        links[0].valid     = pixel.valid;
        links[0].pix.red   = CHANNEL_BITS'(pixel.red);
        links[0].pix.green = CHANNEL_BITS'(pixel.green);
        links[0].pix.blue  = CHANNEL_BITS'(pixel.blue);
        links[0].row_end   = pixel.row_end;
        links[0].best_dist = '0;
        links[0].best_idx  = '0;
    end

    for (genvar i = 0; i < PALETTE_ENTRIES; i++)
    begin : g_cell
        localparam int BASE = (i % 2) * WORD_BITS;
        logic [EXT_BITS-1:0] ext;
        rgb_t                entry;

        assign ext         = EXT_BITS'(pair_reg[i / 2]);
        assign entry.blue  = ext[BASE +: CHANNEL_BITS];
        assign entry.green = ext[BASE + CHANNEL_BITS +: CHANNEL_BITS];
        assign entry.red   = ext[BASE + 2 * CHANNEL_BITS +: CHANNEL_BITS];

        npnp_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .cell_index (NIBBLE_BITS'(i)),
            .entry      (entry),
            .link_in    (links[i]),
            .link_out   (links[i+1])
        );
    end

    npnp_packer u_packer (
        .clk          (clk),
        .rst_n        (rst_n),
        .link_in      (links[PALETTE_ENTRIES]),
        .en           (en),
        .packed_bytes (packed_bytes)
    );

endmodule
